// File: rtl/dart_pkg.sv
// Shared types, constants and helpers for the divider and reload timer.
`timescale 1ns / 1ps

package dart_pkg;

   localparam int CYC_W          = 8;
   localparam int CNT_W          = 8;
   localparam int ACC_W          = 11;
   localparam int SEL_W          = 2;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 8;
   localparam int RSP_DATA_W     = 24;
   localparam int DIV_PERIOD_DEF = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMER_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_SELECT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULO       = 2'd2;

   localparam logic [SEL_W-1:0] SEL_1024 = 2'd0;
   localparam logic [SEL_W-1:0] SEL_16   = 2'd1;
   localparam logic [SEL_W-1:0] SEL_64   = 2'd2;
   localparam logic [SEL_W-1:0] SEL_256  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_TMR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic ready;
      logic use_tmr;
      logic div_step;
      logic tmr_step;
      logic out_load;
   } ctrl_type;

   function automatic logic [ACC_W-1:0] timer_period(input logic [SEL_W-1:0] sel);
      logic [ACC_W-1:0] period;
      case (sel)
         SEL_1024: period = 11'd1024;
         SEL_16:   period = 11'd16;
         SEL_64:   period = 11'd64;
         SEL_256:  period = 11'd256;
         default:  period = 11'd1024;
      endcase
      return period;
   endfunction

endpackage

// File: rtl/dart_cmpsub.sv
// Shared compare and subtract unit used for every period count.
`timescale 1ns / 1ps

module dart_cmpsub
   import dart_pkg::*;
(
   input  logic [ACC_W-1:0] acc,
   input  logic [ACC_W-1:0] period,
   output logic             ge,
   output logic [ACC_W-1:0] diff
);

   logic [ACC_W:0] sub;

   assign sub  = {1'b0, acc} - {1'b0, period};
   assign ge   = ~sub[ACC_W];
   assign diff = sub[ACC_W-1:0];

endmodule

// File: rtl/dart_seq.sv
// Sequencer that steps the shared unit through the divider and timer counts.
`timescale 1ns / 1ps

module dart_seq
   import dart_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_fire,
   input  logic     unit_ge,
   input  logic     timer_enable,
   input  logic     out_free,
   output ctrl_type ctrl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (!unit_ge) begin
               state_in = ST_TMR;
            end
         end
         ST_TMR: begin
            if (!(unit_ge && timer_enable)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: ctrl.ready = 1'b1;
         ST_DIV:  ctrl.div_step = unit_ge;
         ST_TMR: begin
            ctrl.use_tmr  = 1'b1;
            ctrl.tmr_step = unit_ge && timer_enable;
         end
         ST_OUT:  ctrl.out_load = out_free;
         default: ctrl = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_DIV)
      else $error("accepted item did not start the divider pass");

endmodule

// File: rtl/divider_and_reload_timer_top.sv
// Top level of the divider and reload timer with registers and datapath.
`timescale 1ns / 1ps

// The req channel carries one item per step: the number of clock cycles
// elapsed since the previous item. For each item the block returns one
// item on the rsp channel with the divider value, the timer counter value
// and a flag that is set when the counter wrapped and reloaded from the
// modulo register during that step. Timer enable, clock select and modulo
// are written through the csr channel, which is always ready.
// One shared compare and subtract unit removes one period per cycle, first
// for the divider and then for the timer counter. After acceptance an item
// passes through the divider state, the timer state and the output state,
// where its result is loaded, and the block returns to idle and accepts
// again in the cycle after the load. With the default divider period an
// item makes at most one divider count and up to 16 timer counts at a period
// of 16, or up to 79 timer counts right after the clock select shortens it.
// req_tready is high only while the block is idle. The result sits in an
// output register, so the next item is accepted while it waits; if the
// receiver stalls, the following result holds the block until the output
// register frees. Reset clears every register except the output data.

module divider_and_reload_timer_top
   import dart_pkg::*;
#(
   parameter int DIV_PERIOD = DIV_PERIOD_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CYC_W-1:0]      req_tdata,   // [7:0] cycles
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] div_value, [15:8] counter_value,
                                              // [16] timer_interrupt, [23:17] zero
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int DIV_ACC_W = $clog2(DIV_PERIOD + 256);

   ctrl_type ctrl;

   logic                 timer_enable_ff;
   logic [SEL_W-1:0]     clock_select_ff;
   logic [CNT_W-1:0]     modulo_ff;

   logic [DIV_ACC_W-1:0] div_accum_ff;
   logic [DIV_ACC_W-1:0] div_accum_in;
   logic [CNT_W-1:0]     div_count_ff;
   logic [CNT_W-1:0]     div_count_in;
   logic [ACC_W-1:0]     timer_accum_ff;
   logic [ACC_W-1:0]     timer_accum_in;
   logic [CNT_W-1:0]     counter_ff;
   logic [CNT_W-1:0]     counter_in;
   logic                 wrap_ff;
   logic                 wrap_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic             req_fire;
   logic             out_free;
   logic [ACC_W-1:0] unit_acc;
   logic [ACC_W-1:0] unit_period;
   logic             unit_ge;
   logic [ACC_W-1:0] unit_diff;

   assign req_tready = ctrl.ready;
   assign req_fire   = req_tvalid && ctrl.ready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_enable_ff <= 1'b0;
         clock_select_ff <= '0;
         modulo_ff       <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIMER_ENABLE: timer_enable_ff <= csr_data[0];
            CSR_CLOCK_SELECT: clock_select_ff <= csr_data[SEL_W-1:0];
            CSR_MODULO:       modulo_ff       <= csr_data[CNT_W-1:0];
            default:          ;
         endcase
      end
   end

   assign unit_acc    = ctrl.use_tmr ? timer_accum_ff : ACC_W'(div_accum_ff);
   assign unit_period = ctrl.use_tmr ? timer_period(clock_select_ff) : ACC_W'(DIV_PERIOD);

   dart_cmpsub u_cmpsub (
      .acc    (unit_acc),
      .period (unit_period),
      .ge     (unit_ge),
      .diff   (unit_diff)
   );

   dart_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .unit_ge      (unit_ge),
      .timer_enable (timer_enable_ff),
      .out_free     (out_free),
      .ctrl         (ctrl)
   );

   always_comb begin
      div_accum_in   = div_accum_ff;
      div_count_in   = div_count_ff;
      timer_accum_in = timer_accum_ff;
      counter_in     = counter_ff;
      wrap_in        = wrap_ff;
      if (req_fire) begin
         div_accum_in = div_accum_ff + DIV_ACC_W'(req_tdata);
         wrap_in      = 1'b0;
         if (timer_enable_ff) begin
            timer_accum_in = timer_accum_ff + ACC_W'(req_tdata);
         end
      end
      if (ctrl.div_step) begin
         div_accum_in = unit_diff[DIV_ACC_W-1:0];
         div_count_in = div_count_ff + 1'b1;
      end
      if (ctrl.tmr_step) begin
         timer_accum_in = unit_diff;
         if (counter_ff == {CNT_W{1'b1}}) begin
            counter_in = modulo_ff;
            wrap_in    = 1'b1;
         end else begin
            counter_in = counter_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, wrap_ff, counter_ff, div_count_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_accum_ff   <= '0;
         div_count_ff   <= '0;
         timer_accum_ff <= '0;
         counter_ff     <= '0;
         wrap_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         div_accum_ff   <= div_accum_in;
         div_count_ff   <= div_count_in;
         timer_accum_ff <= timer_accum_in;
         counter_ff     <= counter_in;
         wrap_ff        <= wrap_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      ctrl.ready |-> ACC_W'(div_accum_ff) < ACC_W'(DIV_PERIOD))
      else $error("divider remainder left at or above its period");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.tmr_step |-> timer_enable_ff)
      else $error("timer counted while disabled");

   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("block ready again right after accepting an item");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> !rsp_valid_ff || rsp_tready)
      else $error("result loaded over one not yet taken");

endmodule

// File: sim/tb_divider_and_reload_timer_top.sv
// Self-checking testbench for the divider and reload timer stream block.
`timescale 1ns / 1ps

module tb_divider_and_reload_timer_top
   import dart_pkg::*;
();

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEMS_PER_PHASE = 70;
   localparam int PHASES = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic [CNT_W-1:0] div_value;
      logic [CNT_W-1:0] counter_value;
      logic             timer_interrupt;
   } reading_type;

   class timer_tracker;
      bit               enable = 1'b0;
      logic [SEL_W-1:0] rate_sel = SEL_1024;
      logic [CNT_W-1:0] reload = '0;
      int unsigned      div_accum = 0;
      logic [CNT_W-1:0] div_count = '0;
      int unsigned      tick_accum = 0;
      logic [CNT_W-1:0] tima = '0;
      reading_type      pending_readings[$];
      int               errors = 0;

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TIMER_ENABLE: enable = data[0];
            CSR_CLOCK_SELECT: rate_sel = data[SEL_W-1:0];
            CSR_MODULO:       reload = data;
            default: ;
         endcase
      endfunction

      function void note_cycles(logic [CYC_W-1:0] cycles);
         int unsigned period;
         reading_type r;
         r.timer_interrupt = 1'b0;
         div_accum += cycles;
         while (div_accum >= DIV_PERIOD_DEF) begin
            div_accum -= DIV_PERIOD_DEF;
            div_count += 1'b1;
         end
         if (enable) begin
            case (rate_sel)
               SEL_16:  period = 16;
               SEL_64:  period = 64;
               SEL_256: period = 256;
               default: period = 1024;
            endcase
            tick_accum += cycles;
            while (tick_accum >= period) begin
               tick_accum -= period;
               if (tima == 8'hFF) begin
                  tima = reload;
                  r.timer_interrupt = 1'b1;
               end else begin
                  tima += 1'b1;
               end
            end
            tick_accum &= 32'h7FF;
         end
         r.div_value = div_count;
         r.counter_value = tima;
         pending_readings.push_back(r);
      endfunction

      function void check_reading(logic [RSP_DATA_W-1:0] word);
         reading_type r;
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected result %h", $time, word);
            errors++;
            return;
         end
         r = pending_readings.pop_front();
         if (word[7:0] !== r.div_value) begin
            $display("%0t: div_value expected %h actual %h", $time, r.div_value, word[7:0]);
            errors++;
         end
         if (word[15:8] !== r.counter_value) begin
            $display("%0t: counter_value expected %h actual %h", $time, r.counter_value,
                     word[15:8]);
            errors++;
         end
         if (word[16] !== r.timer_interrupt) begin
            $display("%0t: timer_interrupt expected %b actual %b", $time, r.timer_interrupt,
                     word[16]);
            errors++;
         end
         if (word[23:17] !== 7'd0) begin
            $display("%0t: padding expected %h actual %h", $time, 7'd0, word[23:17]);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_readings.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CYC_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   timer_tracker tracker = new;
   int send_idle_pct = 20;
   int recv_idle_pct = 63;
   int hold_left = 0;
   int cycle_count = 0;

   divider_and_reload_timer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Result side: check on each handshake, then pick the ready level for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_reading(rsp_tdata);
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_cycles(input logic [CYC_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      tracker.note_cycles(value);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(posedge clock);
   endtask

   task automatic program_timer(input bit en, input logic [SEL_W-1:0] sel,
                                input logic [CNT_W-1:0] mod);
      logic [CSR_IDX_W-1:0]  idx_list[4];
      logic [CSR_DATA_W-1:0] data_list[4];
      idx_list = '{CSR_TIMER_ENABLE, CSR_CLOCK_SELECT, CSR_MODULO, CSR_SPARE};
      for (int i = 0; i < 4; i++)
         data_list[i] = CSR_DATA_W'($urandom);
      data_list[0][0] = en;
      data_list[1][SEL_W-1:0] = sel;
      data_list[2] = mod;
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx_list[i];
         csr_data <= data_list[i];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         tracker.write_reg(idx_list[i], data_list[i]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [CYC_W-1:0] pick_cycles();
      case ($urandom_range(9))
         0:       return '0;
         1, 2:    return CYC_W'($urandom_range(4, 24));
         default: return CYC_W'($urandom_range(255));
      endcase
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Timer disabled after reset: only the divider moves.
      send_cycles(8'h00);
      send_cycles(8'hFF);
      send_cycles(8'hAA);
      send_cycles(8'h55);
      drain();

      // Shortest period with a reload of 255: first wrap, then a wrap on every count.
      program_timer(1'b1, SEL_16, 8'hFF);
      repeat (17) send_cycles(8'hFF);
      drain();

      // Gather cycles at the longest period, then shorten it with cycles pending.
      program_timer(1'b1, SEL_1024, 8'h0F);
      repeat (3) send_cycles(8'hFF);
      drain();
      program_timer(1'b1, SEL_16, 8'h0F);
      send_cycles(8'h00);
      drain();

      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 20;
               recv_idle_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct = 20;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int phase = 0; phase < PHASES; phase++) begin
            program_timer(phase != 3, SEL_W'(phase + regime),
                          (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : CNT_W'($urandom));
            if (regime == 0 && phase == 2)
               hold_left = 300;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
               if (n == ITEMS_PER_PHASE / 2)
                  drain();
               send_cycles(pick_cycles());
            end
            drain();
         end
      end

      repeat (100) @(posedge clock);
      if (tracker.outstanding() != 0) begin
         $display("%0t: %0d results never arrived", $time, tracker.outstanding());
         tracker.errors++;
      end
      if (tracker.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
rtl/dart_pkg.sv
rtl/dart_cmpsub.sv
rtl/dart_seq.sv
rtl/divider_and_reload_timer_top.sv
sim/tb_divider_and_reload_timer_top.sv
